// ----- design/frustum_cull_sphere_box_core_defines.svh -----
// assertion macros for the frustum cull sphere/box block
`ifndef FRUSTUM_CULL_SPHERE_BOX_CORE_DEFINES_SVH
`define FRUSTUM_CULL_SPHERE_BOX_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FCSB_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FCSB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/fcsb_pkg.sv -----
// shared types, codes and constants of the frustum cull sphere/box block
package fcsb_pkg;

	localparam int NUM_PLANES_DEF  = 6;
	localparam int NUM_CORNERS_DEF = 8;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int COEF_W    = 32;
	localparam int RADIUS_W  = 31;
	localparam int PROD_W    = 64;
	localparam int ACC_W     = 64;
	localparam int NUM_COEFS = 4;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_SPHERE = 2'd1;
	localparam logic [1:0] MODE_CORNER = 2'd2;

	localparam logic [1:0] COEF_A = 2'd0;
	localparam logic [1:0] COEF_B = 2'd1;
	localparam logic [1:0] COEF_C = 2'd2;
	localparam logic [1:0] COEF_D = 2'd3;

	localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
	localparam logic [1:0] VERDICT_OUTSIDE   = 2'd1;
	localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

	typedef struct packed {
		logic [1:0]               mode;
		logic [2:0]               plane_index;
		logic [1:0]               coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [COEF_W-1:0] point_x;
		logic signed [COEF_W-1:0] point_y;
		logic signed [COEF_W-1:0] point_z;
		logic [RADIUS_W-1:0]      radius;
	} req_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic       from_box;
	} rsp_t;

	typedef struct packed {
		logic load_d;
		logic mul;
		logic acc;
	} dot_ctl_t;

endpackage

// ----- design/frustum_cull_sphere_box_core.sv -----
// top level of the frustum cull sphere/box block
// Classifies spheres and boxes against NUM_PLANES stored Q16.16 planes. A load item
// (mode 0) writes one coefficient and never holds the block. A sphere item (mode 1) or a
// box corner (mode 2) runs through one shared multiply-accumulate unit, plane by plane in
// the steps load d, three multiplies, last add and evaluate, and keeps req_stall high
// until it is finished. A box verdict appears with its NUM_CORNERS-th corner; the other
// corners give no result and skip the posting state. The result sits in an output
// register, so new items are taken while it waits on rsp_stall; a later verdict holds in
// its posting state until the register is free.
module frustum_cull_sphere_box_core #(
	parameter int NUM_PLANES  = fcsb_pkg::NUM_PLANES_DEF,
	parameter int NUM_CORNERS = fcsb_pkg::NUM_CORNERS_DEF,
	parameter int FRAC_BITS   = fcsb_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fcsb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fcsb_pkg::rsp_t rsp
);
	import fcsb_pkg::*;

	localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
	localparam int CW = (NUM_CORNERS > 1) ? $clog2(NUM_CORNERS) : 1;
	localparam logic [3:0] PlaneLimit = 4'(NUM_PLANES);
	localparam logic [PW-1:0] LastPlane = PW'(NUM_PLANES - 1);
	localparam logic [CW-1:0] LastCorner = CW'(NUM_CORNERS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_D,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_C,
		ST_ACC_C,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [PW-1:0] plane_q;
	logic [CW-1:0] count_q;
	logic [NUM_PLANES-1:0] some_in_q;
	logic [NUM_PLANES-1:0] all_in_q;
	logic outside_q;
	logic touch_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic signed [COEF_W-1:0] store_q [NUM_PLANES][NUM_COEFS];
	logic signed [COEF_W-1:0] x_q;
	logic signed [COEF_W-1:0] y_q;
	logic signed [COEF_W-1:0] z_q;
	logic [RADIUS_W-1:0] r_q;
	logic is_box_q;

	logic req_xfer;
	logic out_free;
	dot_ctl_t ctl;
	logic [1:0] coef_sel;
	logic signed [COEF_W-1:0] coord;
	logic signed [ACC_W-1:0] dist_sum;
	logic signed [ACC_W-1:0] r_ext;
	logic signed [ACC_W-1:0] dist_plus_r;
	logic [1:0] box_verdict;
	logic [1:0] sphere_verdict;

	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign r_ext       = ACC_W'(signed'({1'b0, r_q}));
	assign dist_plus_r = dist_sum + r_ext;

	always_comb begin
		ctl      = '0;
		coef_sel = COEF_D;
		coord    = x_q;
		case (state_q)
			ST_LOAD_D: begin
				ctl.load_d = 1'b1;
			end
			ST_MUL_A: begin
				ctl.mul  = 1'b1;
				coef_sel = COEF_A;
			end
			ST_MUL_B: begin
				ctl.mul  = 1'b1;
				ctl.acc  = 1'b1;
				coef_sel = COEF_B;
				coord    = y_q;
			end
			ST_MUL_C: begin
				ctl.mul  = 1'b1;
				ctl.acc  = 1'b1;
				coef_sel = COEF_C;
				coord    = z_q;
			end
			ST_ACC_C: begin
				ctl.acc = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	fcsb_dot_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_dot (
		.clk     (clk),
		.ctl     (ctl),
		.coef    (store_q[plane_q][coef_sel]),
		.coord   (coord),
		.dist_sum(dist_sum)
	);

	always_comb begin
		if (some_in_q != {NUM_PLANES{1'b1}}) begin
			box_verdict = VERDICT_OUTSIDE;
		end else if (all_in_q == {NUM_PLANES{1'b1}}) begin
			box_verdict = VERDICT_INSIDE;
		end else begin
			box_verdict = VERDICT_INTERSECT;
		end
		if (outside_q) begin
			sphere_verdict = VERDICT_OUTSIDE;
		end else if (touch_q) begin
			sphere_verdict = VERDICT_INTERSECT;
		end else begin
			sphere_verdict = VERDICT_INSIDE;
		end
	end

	// plane store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int c = 0; c < NUM_COEFS; c++) begin
					store_q[p][c] <= '0;
				end
			end
		end else if (req_xfer && req.mode == MODE_LOAD
				&& {1'b0, req.plane_index} < PlaneLimit) begin
			store_q[req.plane_index[PW-1:0]][req.coef_index] <= req.coef_value;
		end
	end

	// item operands
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			x_q      <= req.point_x;
			y_q      <= req.point_y;
			z_q      <= req.point_z;
			r_q      <= req.radius;
			is_box_q <= (req.mode == MODE_CORNER);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			plane_q     <= '0;
			count_q     <= '0;
			some_in_q   <= '0;
			all_in_q    <= '1;
			outside_q   <= 1'b0;
			touch_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer && (req.mode == MODE_SPHERE || req.mode == MODE_CORNER)) begin
						plane_q   <= '0;
						outside_q <= 1'b0;
						touch_q   <= 1'b0;
						state_q   <= ST_LOAD_D;
					end
				end
				ST_LOAD_D: state_q <= ST_MUL_A;
				ST_MUL_A:  state_q <= ST_MUL_B;
				ST_MUL_B:  state_q <= ST_MUL_C;
				ST_MUL_C:  state_q <= ST_ACC_C;
				ST_ACC_C:  state_q <= ST_EVAL;
				ST_EVAL: begin
					if (is_box_q) begin
						if (dist_sum < 0) begin
							all_in_q[plane_q] <= 1'b0;
						end else begin
							some_in_q[plane_q] <= 1'b1;
						end
					end else begin
						if (dist_plus_r < 0) begin
							outside_q <= 1'b1;
						end
						if (dist_sum < r_ext && dist_plus_r > 0) begin
							touch_q <= 1'b1;
						end
					end
					if (plane_q == LastPlane) begin
						if (is_box_q && count_q != LastCorner) begin
							count_q <= count_q + 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						plane_q <= plane_q + 1'b1;
						state_q <= ST_LOAD_D;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_q.from_box <= is_box_q;
						if (is_box_q) begin
							rsp_q.verdict <= box_verdict;
							count_q       <= '0;
							some_in_q     <= '0;
							all_in_q      <= '1;
						end else begin
							rsp_q.verdict <= sphere_verdict;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- design/fcsb_dot_unit.sv -----
// shared multiply-accumulate unit that builds one plane distance term by term
module fcsb_dot_unit #(
	parameter int FRAC_BITS = fcsb_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  fcsb_pkg::dot_ctl_t               ctl,
	input  logic signed [fcsb_pkg::COEF_W-1:0] coef,
	input  logic signed [fcsb_pkg::COEF_W-1:0] coord,
	output logic signed [fcsb_pkg::ACC_W-1:0]  dist_sum
);
	import fcsb_pkg::*;

	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  term;

	// floor shift of the product
	assign term = ACC_W'(prod_q >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= PROD_W'(coef) * PROD_W'(coord);
		end
		if (ctl.load_d) begin
			acc_q <= ACC_W'(coef);
		end else if (ctl.acc) begin
			acc_q <= acc_q + term;
		end
	end

	assign dist_sum = acc_q;

endmodule

// ----- design/fcsb_checker.sv -----
// port checker for the frustum cull sphere/box block and its bind
`include "frustum_cull_sphere_box_core_defines.svh"

module fcsb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input fcsb_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input fcsb_pkg::rsp_t rsp
);
	import fcsb_pkg::*;

	logic req_xfer;
	logic work_xfer;
	logic load_xfer;

	assign req_xfer  = req_valid && !req_stall;
	assign work_xfer = req_xfer && (req.mode == MODE_SPHERE || req.mode == MODE_CORNER);
	assign load_xfer = req_xfer && req.mode == MODE_LOAD;

	`FCSB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
	`FCSB_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp), "stalled result changed")
	`FCSB_ASSERT_NEXT(a_work_busy, work_xfer, req_stall, "block free right after a test item")
	`FCSB_ASSERT_NEXT(a_load_free, load_xfer, !req_stall, "load transfer held the block")
	`FCSB_ASSERT_NEXT(a_no_fast_rsp, req_xfer, !$rose(rsp_valid), "result raised right after a transfer")

endmodule

bind frustum_cull_sphere_box_core fcsb_checker u_fcsb_checker (.*);
